/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands. They expand to nothing when SYNTH is
// defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is held.
`define CHM_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CHM_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CHM_ASSERT_IMPLY(label, ck, rn, ante, cons, msg)
`define CHM_ASSERT_NEXT(label, ck, rn, ante, cons, msg)

`endif

`endif

/* src/chm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg
// Types, constants and the cone radius thresholds shared by the cone
// heightmap unit.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int MAX_SEEDS_DEF   = 32;
  localparam int COORD_BITS_DEF  = 10;
  localparam int HEIGHT_BITS_DEF = 4;

  localparam int COUNT_BITS = 6;
  localparam int INDEX_BITS = 5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } chm_state_t;

  // Controls from the sequencer to the cone pipeline.
  typedef struct packed {
    logic start;   // clears the running maximum for a new cell
    logic rd_en;   // a seed entry is read from memory this cycle
  } chm_ctrl_t;

  // Radius s is reached when 25*d >= (5*s - 2)^2.
  function automatic int unsigned cone_thresh(input int unsigned s);
    int unsigned t;
    t = 5 * s - 2;
    return t * t;
  endfunction

endpackage

/* src/chm_seed_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_seed_mem
// Seed table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chm_seed_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int EW    = 24
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [EW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [EW-1:0] rd_data
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/chm_cone_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_cone_pipe
// Per-seed cone pipeline: distance, squares, 25*d, cone value, running max.
// ----------------------------------------------------------------------------
module chm_cone_pipe
  import chm_pkg::*;
#(
  parameter int C  = 10,
  parameter int H  = 4,
  parameter int EW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  chm_ctrl_t     ctrl,
  input  logic [EW-1:0] rd_data,
  input  logic [C-1:0]  cell_x,
  input  logic [C-1:0]  cell_y,
  output logic          busy,
  output logic [H-1:0]  best
);

  localparam int SW   = 2 * C + 1;
  localparam int DW   = 2 * C + 6;
  localparam int TW   = 2 * H + 6;
  localparam int CW   = (DW > TW) ? DW : TW;
  localparam int MAXH = (1 << H) - 1;

  logic [C-1:0]  seed_x;
  logic [C-1:0]  seed_y;
  logic [H-1:0]  seed_pk;

  logic          v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [C-1:0]  dx_r, dy_r;
  logic [H-1:0]  pk2_r, pk3_r, pk4_r, pk5_r;
  logic [2*C-1:0] sqx_r, sqy_r;
  logic [SW-1:0] dsum_r;
  logic [DW-1:0] d25_r;
  logic [H-1:0]  val_r, val_nxt;
  logic [H-1:0]  best_r;
  logic [H-1:0]  reached;

  assign seed_x  = rd_data[EW-1 -: C];
  assign seed_y  = rd_data[EW-1-C -: C];
  assign seed_pk = rd_data[H-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= ctrl.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r   <= (seed_x > cell_x) ? seed_x - cell_x : cell_x - seed_x;
    dy_r   <= (seed_y > cell_y) ? seed_y - cell_y : cell_y - seed_y;
    pk2_r  <= seed_pk;
    sqx_r  <= (2*C)'(dx_r) * (2*C)'(dx_r);
    sqy_r  <= (2*C)'(dy_r) * (2*C)'(dy_r);
    pk3_r  <= pk2_r;
    dsum_r <= SW'(sqx_r) + SW'(sqy_r);
    pk4_r  <= pk3_r;
    d25_r  <= (DW'(dsum_r) << 4) + (DW'(dsum_r) << 3) + DW'(dsum_r);
    pk5_r  <= pk4_r;
    val_r  <= val_nxt;
  end

  // Thresholds grow with s, so the last radius that passes is the rounded radius.
  always_comb begin
    reached = '0;
    for (int s = 1; s <= MAXH; s++) begin
      if ((H'(s) <= pk5_r) && (CW'(d25_r) >= CW'(cone_thresh(s)))) begin
        reached = H'(s);
      end
    end
    val_nxt = pk5_r - reached;
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      best_r <= '0;
    end else if (v6_r && (val_r > best_r)) begin
      best_r <= val_r;
    end
  end

  assign busy = v1_r | v2_r | v3_r | v4_r | v5_r | v6_r;
  assign best = best_r;

endmodule

/* src/cone_heightmap_max_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cone_heightmap_max_unit
// Heightmap cell evaluator: the maximum height of a set of seed cones at one
// cell, with the seeds kept in an on-chip table.
// ----------------------------------------------------------------------------
// An item with in_mode low writes seed in_seed_index (x, y, peak) into the
// seed table and gives no result; an index past the table is
// dropped. An item with in_mode high evaluates the cell (in_pos_x, in_pos_y)
// against the first seed_count entries (seed_count is capped at MAX_SEEDS)
// and gives exactly one result item, the height. Each seed is read once from
// the single read port of the seed memory, one seed per cycle, and runs
// through a six-stage cone pipeline. An evaluation holds in_stall high from
// acceptance until the last seed has left the pipeline and its result is
// loaded into the output register, so a new item is taken only once the
// previous evaluation is done; a result that still waits on out_stall when
// the next one is ready keeps in_stall high longer. The output register lets
// the next item be accepted while a result still waits on out_stall. Seeds
// must be written before a cell evaluation reads them; unwritten entries
// give undefined heights.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cone_heightmap_max_unit
  import chm_pkg::*;
#(
  parameter int MAX_SEEDS   = MAX_SEEDS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration: seed_count.
  input  logic                   cfg_wr_en,
  input  logic [COUNT_BITS-1:0]  cfg_wr_data,
  // Input items.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [INDEX_BITS-1:0]  in_seed_index,
  input  logic [COORD_BITS-1:0]  in_pos_x,
  input  logic [COORD_BITS-1:0]  in_pos_y,
  input  logic [HEIGHT_BITS-1:0] in_peak,
  // Result items.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [HEIGHT_BITS-1:0] out_height
);

  localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int NW = $clog2(MAX_SEEDS + 1);
  localparam int EW = 2 * COORD_BITS + HEIGHT_BITS;

  chm_state_t state_r, state_nxt;
  chm_ctrl_t  ctrl;

  logic [COUNT_BITS-1:0]  seed_count_r;
  logic [NW-1:0]          n_r, n_eff;
  logic [NW-1:0]          issue_r;
  logic [COORD_BITS-1:0]  cell_x_r, cell_y_r;
  logic                   out_valid_r;
  logic [HEIGHT_BITS-1:0] out_height_r;

  logic                   in_accept;
  logic                   out_free;
  logic                   load_out;
  logic                   issue_left;
  logic                   mem_wr_en;
  logic [31:0]            idx_wide;
  logic [EW-1:0]          mem_rd_data;
  logic                   pipe_busy;
  logic [HEIGHT_BITS-1:0] pipe_best;

  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign issue_left = (issue_r < n_r);

  // The seed count saturates at the table depth.
  assign n_eff = (32'(seed_count_r) > 32'(MAX_SEEDS)) ? NW'(MAX_SEEDS)
                                                     : NW'(seed_count_r);

  assign idx_wide  = 32'(in_seed_index);
  assign mem_wr_en = in_accept && (in_mode == MODE_WRITE) &&
                     (idx_wide < 32'(MAX_SEEDS));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_mode == MODE_EVAL)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!issue_left && !pipe_busy) begin
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs. Items are taken only in the idle state, which also
  // keeps seed writes apart from the reads of an evaluation.
  always_comb begin
    in_stall   = 1'b1;
    ctrl.start = 1'b0;
    ctrl.rd_en = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        ctrl.start = in_valid && (in_mode == MODE_EVAL);
      end
      ST_RUN: begin
        ctrl.rd_en = issue_left;
        load_out   = !issue_left && !pipe_busy && out_free;
      end
      ST_HOLD: begin
        load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seed_count_r <= '0;
      issue_r      <= '0;
      n_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        seed_count_r <= cfg_wr_data;
      end
      if (ctrl.start) begin
        issue_r <= '0;
        n_r     <= n_eff;
      end else if (ctrl.rd_en) begin
        issue_r <= issue_r + NW'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cell_x_r <= in_pos_x;
      cell_y_r <= in_pos_y;
    end
    if (load_out) begin
      out_height_r <= pipe_best;
    end
  end

  chm_seed_mem #(
    .DEPTH (MAX_SEEDS),
    .AW    (AW),
    .EW    (EW)
  ) u_seed_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (idx_wide[AW-1:0]),
    .wr_data ({in_pos_x, in_pos_y, in_peak}),
    .rd_en   (ctrl.rd_en),
    .rd_addr (issue_r[AW-1:0]),
    .rd_data (mem_rd_data)
  );

  chm_cone_pipe #(
    .C  (COORD_BITS),
    .H  (HEIGHT_BITS),
    .EW (EW)
  ) u_cone_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rd_data (mem_rd_data),
    .cell_x  (cell_x_r),
    .cell_y  (cell_y_r),
    .busy    (pipe_busy),
    .best    (pipe_best)
  );

  assign out_valid  = out_valid_r;
  assign out_height = out_height_r;

  // Seeds are only in flight during an evaluation.
  `CHM_ASSERT_IMPLY(a_busy_in_run, clk, rst_n, pipe_busy, state_r == ST_RUN, "pipeline busy outside run")

  // The read pointer never runs past the saturated seed count.
  `CHM_ASSERT_IMPLY(a_issue_bound, clk, rst_n, state_r == ST_RUN, issue_r <= n_r, "seed read past count")

  // An accepted cell request starts an evaluation.
  `CHM_ASSERT_NEXT(a_eval_starts, clk, rst_n, in_accept && (in_mode == MODE_EVAL), state_r == ST_RUN, "evaluation did not start")

  // A finished result only waits while the output register is still full.
  `CHM_ASSERT_IMPLY(a_hold_full, clk, rst_n, state_r == ST_HOLD, out_valid_r, "hold without pending result")

endmodule

/* verif/chm_height_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_height_checker
// Watches the item channels of the cone heightmap unit, keeps its own copy of
// the seed table and seed_count, predicts the height of each evaluated cell
// and compares every result item against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module chm_height_checker
  import chm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [COUNT_BITS-1:0]      cfg_wr_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_mode,
  input  logic [INDEX_BITS-1:0]      in_seed_index,
  input  logic [COORD_BITS_DEF-1:0]  in_pos_x,
  input  logic [COORD_BITS_DEF-1:0]  in_pos_y,
  input  logic [HEIGHT_BITS_DEF-1:0] in_peak,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [HEIGHT_BITS_DEF-1:0] out_height,
  output int                         heights_owed,
  output int                         mismatches
);

  localparam int CB           = COORD_BITS_DEF;
  localparam int HB           = HEIGHT_BITS_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [HB-1:0] pk;
  } seed_t;

  seed_t         seeds [MAX_SEEDS_DEF];
  int unsigned   seed_count = 0;
  logic [HB-1:0] height_due [$];
  logic [HB-1:0] want;

  initial begin
    heights_owed = 0;
    mismatches   = 0;
  end

  // Highest cone over the active seeds. The rounded radius of a seed is the
  // largest s with 25*d >= (5*s - 2)^2, stopped at the seed's peak.
  function automatic logic [HB-1:0] cell_height(input logic [CB-1:0] cx,
                                                input logic [CB-1:0] cy);
    int unsigned n, i, dx, dy, d, s, reach, best;
    best = 0;
    n = (seed_count > MAX_SEEDS_DEF) ? MAX_SEEDS_DEF : seed_count;
    for (i = 0; i < n; i++) begin
      dx = (seeds[i].x > cx) ? seeds[i].x - cx : cx - seeds[i].x;
      dy = (seeds[i].y > cy) ? seeds[i].y - cy : cy - seeds[i].y;
      d = dx * dx + dy * dy;
      reach = 0;
      s = 1;
      while (s <= seeds[i].pk && 25 * d >= (5 * s - 2) * (5 * s - 2)) begin
        reach = s;
        s++;
      end
      if (seeds[i].pk - reach > best) best = seeds[i].pk - reach;
    end
    return best[HB-1:0];
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Sampled mid-cycle: everything seen here takes effect at the next edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      height_due.delete();
      seed_count = 0;
      foreach (seeds[i]) seeds[i] = '{default: '0};
    end else begin
      if (cfg_wr_en) seed_count = 32'(cfg_wr_data);
      if (out_valid && !out_stall) begin
        if (height_due.size() == 0) begin
          flag_mismatch($sformatf("height %0d with nothing expected", out_height));
        end else begin
          want = height_due.pop_front();
          if (out_height !== want)
            flag_mismatch($sformatf("height expected %0d, got %0d", want, out_height));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_mode == MODE_EVAL) begin
          height_due.push_back(cell_height(in_pos_x, in_pos_y));
        end else if (in_seed_index < MAX_SEEDS_DEF) begin
          seeds[in_seed_index] = '{x: in_pos_x, y: in_pos_y, pk: in_peak};
        end
      end
    end
    heights_owed = height_due.size();
  end

endmodule

/* verif/cone_heightmap_max_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cone_heightmap_max_unit_test
// Drives seed writes and cell evaluations into the cone heightmap unit under
// random sender gaps and receiver stalls, moves seed_count through a series of
// settings while the unit is idle, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module cone_heightmap_max_unit_test;
  import chm_pkg::*;

  localparam int CB             = COORD_BITS_DEF;
  localparam int HB             = HEIGHT_BITS_DEF;
  localparam int COORD_MAX      = (1 << CB) - 1;
  localparam int PEAK_MAX       = (1 << HB) - 1;
  // This many quiet cycles outlast an evaluation with a full table, so they
  // leave nothing in flight.
  localparam int SETTLE_CYCLES  = 48;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 11;
  localparam int PHASE_ITEMS    = 110;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    cfg_wr_en     = 1'b0;
  logic [COUNT_BITS-1:0]   cfg_wr_data   = '0;
  logic                    in_valid      = 1'b0;
  logic                    in_mode       = MODE_WRITE;
  logic [INDEX_BITS-1:0]   in_seed_index = '0;
  logic [CB-1:0]           in_pos_x      = '0;
  logic [CB-1:0]           in_pos_y      = '0;
  logic [HB-1:0]           in_peak       = '0;
  logic                    out_stall     = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic [HB-1:0]           out_height;

  int heights_owed;
  int mismatches;

  // Receiver behavior, set by the stimulus process and read by the stall
  // process. Bumping hold_tag asks for one long hold-off.
  int stall_pct   = 0;
  int hold_tag    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int stall_run   = 0;
  int idle_cycles = 0;

  // What the stimulus knows about the table, used only to aim cells at cones.
  logic [CB-1:0] seed_x  [MAX_SEEDS_DEF];
  logic [CB-1:0] seed_y  [MAX_SEEDS_DEF];
  logic [HB-1:0] seed_pk [MAX_SEEDS_DEF];
  int active_count = 0;
  int gap_pct      = 0;
  int center_x     = 0;
  int center_y     = 0;

  // The seed_count of each random phase: full, saturating values past the
  // table, empty, one seed, and a few in between.
  int phase_counts [PHASES] = '{32, 63, 1, 0, 33, 16, 31, 2, 48, 32, 5};

  cone_heightmap_max_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_seed_index (in_seed_index),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_peak       (in_peak),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_height    (out_height)
  );

  chm_height_checker height_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_seed_index (in_seed_index),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_peak       (in_peak),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_height    (out_height),
    .heights_owed  (heights_owed),
    .mismatches    (mismatches)
  );

  always #5 clk = ~clk;

  // Length of one idle stretch: mostly a short one, now and then a long one.
  function automatic int burst_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // A coordinate within span of c, clamped to the grid.
  function automatic int near(input int c, input int span);
    int v;
    v = c + $urandom_range(0, 2 * span) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // Seed coordinates crowd around the phase's center so that cones overlap,
  // with some spread over the whole grid and some on its edges.
  function automatic int spread_coord(input int c);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return near(c, 24);
      5, 6, 7:       return $urandom_range(0, COORD_MAX);
      8:             return 0;
      default:       return COORD_MAX;
    endcase
  endfunction

  function automatic int pick_peak();
    case ($urandom_range(0, 7))
      0, 1:    return PEAK_MAX;
      2:       return 0;
      default: return $urandom_range(0, PEAK_MAX);
    endcase
  endfunction

  // The receiver. A requested hold-off overrides everything until its countdown
  // from HOLD_CYCLES ends; else it draws random runs of stalling or taking items.
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left != 1);
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_run <= burst_length();
    end else begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(0, 7);
    end
  end

  // Watchdog: a hung handshake shows up as a long run of cycles in which no
  // item moves on either channel and no register is written.
  always @(negedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one item and returns at the edge that accepts it, then maybe
  // leaves a gap. Acceptance is judged at the falling edge, where in_stall is
  // settled. in_valid stays high into the next item when there is no gap.
  task automatic offer_item(input logic m, input logic [INDEX_BITS-1:0] idx,
                            input int x, input int y, input int pk);
    bit took;
    int gap;
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_seed_index <= idx;
    in_pos_x      <= x[CB-1:0];
    in_pos_y      <= y[CB-1:0];
    in_peak       <= pk[HB-1:0];
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end
    gap = ($urandom_range(0, 99) < gap_pct) ? burst_length() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_seed(input int idx, input int x, input int y, input int pk);
    seed_x[idx]  = x[CB-1:0];
    seed_y[idx]  = y[CB-1:0];
    seed_pk[idx] = pk[HB-1:0];
    offer_item(MODE_WRITE, idx[INDEX_BITS-1:0], x, y, pk);
  endtask

  // Index and peak are don't-care for an evaluation, so they carry noise.
  task automatic eval_cell(input int x, input int y);
    offer_item(MODE_EVAL, INDEX_BITS'($urandom_range(0, MAX_SEEDS_DEF - 1)), x, y,
               $urandom_range(0, PEAK_MAX));
  endtask

  // Cells are mostly aimed at the slope of an active cone, where the radius
  // rounding matters; the rest fall near the cluster or anywhere.
  task automatic random_eval();
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        if (active_count > 0) begin
          k = $urandom_range(0, active_count - 1);
          eval_cell(near(int'(seed_x[k]), int'(seed_pk[k]) + 3),
                    near(int'(seed_y[k]), int'(seed_pk[k]) + 3));
        end else begin
          eval_cell(near(center_x, 30), near(center_y, 30));
        end
      end
      6, 7:    eval_cell(near(center_x, 30), near(center_y, 30));
      default: eval_cell(spread_coord(center_x), spread_coord(center_y));
    endcase
  endtask

  task automatic random_item();
    if ($urandom_range(0, 99) < 35)
      write_seed($urandom_range(0, MAX_SEEDS_DEF - 1), spread_coord(center_x),
                 spread_coord(center_y), pick_peak());
    else
      random_eval();
  endtask

  // seed_count is only written with the unit idle: the sender stops, every
  // owed height is collected, and the pipeline is given time to drain.
  task automatic set_seed_count(input int v);
    in_valid <= 1'b0;
    while (heights_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[COUNT_BITS-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_count = (v > MAX_SEEDS_DEF) ? MAX_SEEDS_DEF : v;
  endtask

  initial begin
    int p, i;
    foreach (seed_x[j]) begin
      seed_x[j]  = '0;
      seed_y[j]  = '0;
      seed_pk[j] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With seed_count at its reset value of zero every cell is
    // flat, even in the grid's far corners.
    set_seed_count(0);
    eval_cell(0, 0);
    eval_cell(COORD_MAX, COORD_MAX);

    // Four seeds: full peaks in opposite corners, a zero peak in the middle,
    // and a mid-height cone away from the edges.
    write_seed(0, 0, 0, PEAK_MAX);
    write_seed(1, COORD_MAX, COORD_MAX, PEAK_MAX);
    write_seed(2, 512, 512, 0);
    write_seed(3, 100, 200, 7);
    set_seed_count(4);

    // Tops of the cones, the empty corners, the zero peak, and points on the
    // slope where the rounded radius steps (distance 1, sqrt 5, 3 and 5).
    eval_cell(0, 0);
    eval_cell(COORD_MAX, COORD_MAX);
    eval_cell(COORD_MAX, 0);
    eval_cell(0, COORD_MAX);
    eval_cell(512, 512);
    eval_cell(100, 200);
    eval_cell(101, 200);
    eval_cell(102, 201);
    eval_cell(100, 203);
    eval_cell(105, 200);
    eval_cell(600, 600);

    // Fill phase: every table entry gets written in order, with random cells
    // in between that only look at the four seeds known so far.
    gap_pct = 20;
    stall_pct <= 20;
    center_x = $urandom_range(0, COORD_MAX);
    center_y = $urandom_range(0, COORD_MAX);
    for (i = 0; i < MAX_SEEDS_DEF; i++) begin
      write_seed(i, spread_coord(center_x), spread_coord(center_y), pick_peak());
      if ($urandom_range(0, 1) == 0) random_eval();
    end

    // Random phases. The whole table is written now, so any seed_count is
    // legal. Idling varies from phase to phase, including none at all.
    for (p = 0; p < PHASES; p++) begin
      set_seed_count(phase_counts[p]);
      center_x = $urandom_range(0, COORD_MAX);
      center_y = $urandom_range(0, COORD_MAX);
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct = 20;
          stall_pct <= 20;
        end
        2: begin
          gap_pct = 50;
          stall_pct <= 50;
        end
        default: begin
          gap_pct = 10;
          stall_pct <= 70;
        end
      endcase
      // Twice the receiver holds off for a long stretch while the sender
      // keeps going, so the output register and the pipeline back up.
      if (p == 2 || p == 7) begin
        gap_pct = 0;
        hold_tag <= hold_tag + 1;
      end
      repeat (PHASE_ITEMS) random_item();
    end

    in_valid <= 1'b0;
    while (heights_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/chm_pkg.sv
src/chm_seed_mem.sv
src/chm_cone_pipe.sv
src/cone_heightmap_max_unit.sv
verif/chm_height_checker.sv
verif/cone_heightmap_max_unit_test.sv
